// ===== rtl/core/rrpm_pkg.sv =====
// Package for the RGB run pattern matcher: types, constants and pixel compare functions.
`default_nettype none

package rrpm_pkg;

    // Pattern and field sizes
    localparam int PATTERN_MAX  = 5;
    localparam int WINDOW_DEPTH = PATTERN_MAX - 1;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int COORD_W      = 12;
    localparam int ORD_W        = 24;
    localparam int LEN_W        = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int REF_PAIR_W   = 2 * COLOR_W;

    // Saturation tops
    localparam logic [COORD_W-1:0] ROW_TOP = '1;
    localparam logic [ORD_W-1:0]   ORD_TOP = '1;

    // Register reset values
    localparam logic [LEN_W-1:0]   RUN_LENGTH_RST = 3'd3;
    localparam logic [CHAN_W-1:0]  TOLERANCE_RST  = 8'd3;
    localparam logic [COORD_W-1:0] LINE_WIDTH_RST = 12'd1920;
    localparam logic [COORD_W-1:0] ROW_LIMIT_RST  = 12'd1080;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_COLORS_A = 3'd0,
        REG_COLORS_B = 3'd1,
        REG_COLOR_C  = 3'd2,
        REG_RUN_LEN  = 3'd3,
        REG_TOL      = 3'd4,
        REG_LINE_W   = 3'd5,
        REG_ROW_LIM  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef logic [LEN_W-1:0] run_len_t;

    // Inclusive absolute-difference test on one channel
    function automatic logic chan_close(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] tol
    );
        logic [CHAN_W-1:0] diff;
        diff = (a >= b) ? (a - b) : (b - a);
        return diff <= tol;
    endfunction

    function automatic logic pixel_close(
        input pixel_t            p,
        input pixel_t            r,
        input logic [CHAN_W-1:0] tol
    );
        return chan_close(p.red, r.red, tol)
            && chan_close(p.green, r.green, tol)
            && chan_close(p.blue, r.blue, tol);
    endfunction

    // Clamp the run length register to 1..PATTERN_MAX
    function automatic run_len_t eff_len(input run_len_t len);
        run_len_t res;
        if (len == '0)
            res = run_len_t'(1);
        else if (len > run_len_t'(PATTERN_MAX))
            res = run_len_t'(PATTERN_MAX);
        else
            res = len;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb_run_pattern_matcher.sv =====
// Top level of the RGB run pattern matcher: config registers, pixel window and match logic.
//
// Usage:
//   Pixels enter on the pix channel (red, green, blue, frame_start) in raster
//   order, one transaction per pixel, with pix_valid/pix_stall. Results leave on
//   the match channel (match_x, match_y, match_ordinal) with match_valid and
//   match_stall. A pixel that completes a run equal, within tolerance, to the
//   reference colors gives one result; any other pixel gives none.
//   A pixel taken into the input register is compared there and its result is
//   loaded into the result register. Throughput: one pixel per clock unless a match
//   is stalled, set by the single compare stage between input and result register.
//   When the receiver stalls with a result waiting, pixels that give no match
//   still pass; a matching pixel waits in the input register and pix_stall is
//   raised until the result register frees.
//   Reset (rst_n low) clears the counters, pixel window and both valid flags and
//   loads the register defaults (run length 3, tolerance 3, 1920 x 1080).
//   frame_start clears column, row and match count before its pixel is tested.
//   Registers sit on the APB port at byte address 8*i; write only while idle.
`default_nettype none

module rgb_run_pattern_matcher
    import rrpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Pixel input channel
    input  wire logic                  pix_valid,
    output logic                       pix_stall,
    input  wire logic [CHAN_W-1:0]     red,
    input  wire logic [CHAN_W-1:0]     green,
    input  wire logic [CHAN_W-1:0]     blue,
    input  wire logic                  frame_start,

    // Match output channel
    output logic                       match_valid,
    input  wire logic                  match_stall,
    output logic [COORD_W-1:0]         match_x,
    output logic [COORD_W-1:0]         match_y,
    output logic [ORD_W-1:0]           match_ordinal,

    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Configuration registers
    logic [REF_PAIR_W-1:0] ref_a_reg;
    logic [REF_PAIR_W-1:0] ref_b_reg;
    logic [COLOR_W-1:0]    ref_c_reg;
    run_len_t              run_len_reg;
    logic [CHAN_W-1:0]     tol_reg;
    logic [COORD_W-1:0]    line_width_reg;
    logic [COORD_W-1:0]    row_limit_reg;

    // Input register
    logic                  s1_valid_reg;
    pixel_t                s1_pix_reg;
    logic                  s1_fs_reg;

    // Line state
    pixel_t                window_reg [WINDOW_DEPTH];
    logic [COORD_W-1:0]    col_reg;
    logic [COORD_W-1:0]    row_reg;
    logic [ORD_W-1:0]      matches_reg;
    logic [COORD_W-1:0]    col_next;
    logic [COORD_W-1:0]    row_next;
    logic [ORD_W-1:0]      matches_next;

    // Result register
    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg;
    logic [COORD_W-1:0]    out_y_reg;
    logic [ORD_W-1:0]      out_ord_reg;

    // Compare datapath
    cfg_reg_t              cfg_idx;
    logic                  cfg_wr;
    run_len_t              len;
    logic [COORD_W-1:0]    col_cur;
    logic [COORD_W-1:0]    row_cur;
    logic [ORD_W-1:0]      matches_cur;
    logic [COORD_W:0]      col_plus;
    logic                  in_range;
    logic [PATTERN_MAX-1:0] pos_ok;
    logic                  hit;
    logic [COORD_W:0]      start_x;
    logic                  s1_adv;
    logic                  out_load;
    pixel_t                seq [PATTERN_MAX];
    pixel_t                refs [PATTERN_MAX];

    assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_a_reg      <= '0;
            ref_b_reg      <= '0;
            ref_c_reg      <= '0;
            run_len_reg    <= RUN_LENGTH_RST;
            tol_reg        <= TOLERANCE_RST;
            line_width_reg <= LINE_WIDTH_RST;
            row_limit_reg  <= ROW_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COLORS_A: ref_a_reg      <= pwdata[REF_PAIR_W-1:0];
                REG_COLORS_B: ref_b_reg      <= pwdata[REF_PAIR_W-1:0];
                REG_COLOR_C:  ref_c_reg      <= pwdata[COLOR_W-1:0];
                REG_RUN_LEN:  run_len_reg    <= pwdata[LEN_W-1:0];
                REG_TOL:      tol_reg        <= pwdata[CHAN_W-1:0];
                REG_LINE_W:   line_width_reg <= pwdata[COORD_W-1:0];
                REG_ROW_LIM:  row_limit_reg  <= pwdata[COORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (cfg_idx)
            REG_COLORS_A: prdata = CFG_DATA_W'(ref_a_reg);
            REG_COLORS_B: prdata = CFG_DATA_W'(ref_b_reg);
            REG_COLOR_C:  prdata = CFG_DATA_W'(ref_c_reg);
            REG_RUN_LEN:  prdata = CFG_DATA_W'(run_len_reg);
            REG_TOL:      prdata = CFG_DATA_W'(tol_reg);
            REG_LINE_W:   prdata = CFG_DATA_W'(line_width_reg);
            REG_ROW_LIM:  prdata = CFG_DATA_W'(row_limit_reg);
            default:      prdata = '0;
        endcase
    end

    // Counters as seen by the pixel in the input register
    assign len         = eff_len(run_len_reg);
    assign col_cur     = s1_fs_reg ? '0 : col_reg;
    assign row_cur     = s1_fs_reg ? '0 : row_reg;
    assign matches_cur = s1_fs_reg ? '0 : matches_reg;
    assign col_plus    = {1'b0, col_cur} + (COORD_W+1)'(1);
    assign in_range    = (col_plus >= (COORD_W+1)'(len))
                      && (col_plus < {1'b0, line_width_reg})
                      && (row_cur < row_limit_reg);
    assign start_x     = col_plus - (COORD_W+1)'(len);

    // Newest pixel first, then the window
    assign refs[0] = ref_a_reg[COLOR_W-1:0];
    assign refs[1] = ref_a_reg[REF_PAIR_W-1:COLOR_W];
    assign refs[2] = ref_b_reg[COLOR_W-1:0];
    assign refs[3] = ref_b_reg[REF_PAIR_W-1:COLOR_W];
    assign refs[4] = ref_c_reg;

    always_comb
    begin
        seq[0] = s1_pix_reg;
        for (int k = 1; k < PATTERN_MAX; k++)
            seq[k] = window_reg[k-1];
    end

    // Run position i holds the pixel len-1-i steps back
    always_comb
    begin
        run_len_t sel;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            sel = len - run_len_t'(1) - run_len_t'(i);
            if (run_len_t'(i) >= len)
                pos_ok[i] = 1'b1;
            else if (sel < run_len_t'(PATTERN_MAX))
                pos_ok[i] = pixel_close(seq[sel], refs[i], tol_reg);
            else
                pos_ok[i] = 1'b0;
        end
    end

    assign hit = in_range && (&pos_ok);

    // Flow control: a pixel moves on unless its result finds the output busy
    assign s1_adv    = s1_valid_reg && (!hit || !out_valid_reg || !match_stall);
    assign out_load  = s1_adv && hit;
    assign pix_stall = s1_valid_reg && !s1_adv;

    // Next column, row and match count
    always_comb
    begin
        if (col_plus >= {1'b0, line_width_reg})
        begin
            col_next = '0;
            row_next = (row_cur < ROW_TOP) ? row_cur + COORD_W'(1) : row_cur;
        end
        else
        begin
            col_next = col_plus[COORD_W-1:0];
            row_next = row_cur;
        end
        if (hit && (matches_cur < ORD_TOP))
            matches_next = matches_cur + ORD_W'(1);
        else
            matches_next = matches_cur;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pix_reg   <= '0;
            s1_fs_reg    <= 1'b0;
        end
        else if (pix_valid && !pix_stall)
        begin
            s1_valid_reg <= 1'b1;
            s1_pix_reg   <= '{red: red, green: green, blue: blue};
            s1_fs_reg    <= frame_start;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Window and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
                window_reg[k] <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            matches_reg <= '0;
        end
        else if (s1_adv)
        begin
            window_reg[0] <= s1_pix_reg;
            for (int k = 1; k < WINDOW_DEPTH; k++)
                window_reg[k] <= window_reg[k-1];
            col_reg     <= col_next;
            row_reg     <= row_next;
            matches_reg <= matches_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!match_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg   <= start_x[COORD_W-1:0];
            out_y_reg   <= row_cur;
            out_ord_reg <= matches_cur;
        end
    end

    assign match_valid   = out_valid_reg;
    assign match_x       = out_x_reg;
    assign match_y       = out_y_reg;
    assign match_ordinal = out_ord_reg;

`ifndef SYNTHESIS
    // Stall only with a matching pixel held against a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (s1_valid_reg && hit && out_valid_reg && match_stall))
        else $error("pix_stall raised without a blocked result");

    // A held pixel keeps its data
    a_hold_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("held pixel changed or dropped");

    // A match on a frame-start pixel is ordinal zero
    a_first_ord: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_fs_reg) |=> (out_ord_reg == '0))
        else $error("frame-start match not ordinal zero");

    // Match count steps by one per unsaturated match within a frame
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !s1_fs_reg && (matches_reg != ORD_TOP))
        |=> (matches_reg == $past(matches_reg) + ORD_W'(1)))
        else $error("match count did not advance");

    // A loaded result shows up on the output
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> match_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RGB run pattern matcher: predictor, drivers and checks.
module tb_top
    import rrpm_pkg::*;
();

    localparam int NUM_REGS    = int'(REG_ROW_LIM) + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_MAX   = 10;

    // Predicts match results from accepted pixels and checks what the block returns
    class match_tracker;
        typedef struct {
            logic [COORD_W-1:0] x;
            logic [COORD_W-1:0] y;
            logic [ORD_W-1:0]   ord;
        } match_rec_t;

        match_rec_t         expected_matches[$];
        logic [47:0]        colors_a;
        logic [47:0]        colors_b;
        logic [23:0]        color_c;
        run_len_t           run_len;
        logic [7:0]         tol;
        logic [COORD_W-1:0] line_w;
        logic [COORD_W-1:0] row_lim;
        pixel_t             window[WINDOW_DEPTH];
        logic [COORD_W-1:0] col_cnt;
        logic [COORD_W-1:0] row_cnt;
        logic [ORD_W-1:0]   match_cnt;
        int                 errors;

        function new();
            colors_a  = '0;
            colors_b  = '0;
            color_c   = '0;
            run_len   = RUN_LENGTH_RST;
            tol       = TOLERANCE_RST;
            line_w    = LINE_WIDTH_RST;
            row_lim   = ROW_LIMIT_RST;
            col_cnt   = '0;
            row_cnt   = '0;
            match_cnt = '0;
            errors    = 0;
            foreach (window[i])
                window[i] = '0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [63:0] v);
            case (r)
                REG_COLORS_A: colors_a = v[47:0];
                REG_COLORS_B: colors_b = v[47:0];
                REG_COLOR_C:  color_c  = v[23:0];
                REG_RUN_LEN:  run_len  = v[LEN_W-1:0];
                REG_TOL:      tol      = v[7:0];
                REG_LINE_W:   line_w   = v[COORD_W-1:0];
                REG_ROW_LIM:  row_lim  = v[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] reg_value(cfg_reg_t r);
            case (r)
                REG_COLORS_A: return 64'(colors_a);
                REG_COLORS_B: return 64'(colors_b);
                REG_COLOR_C:  return 64'(color_c);
                REG_RUN_LEN:  return 64'(run_len);
                REG_TOL:      return 64'(tol);
                REG_LINE_W:   return 64'(line_w);
                default:      return 64'(row_lim);
            endcase
        endfunction

        // Run length as the block uses it: zero counts as one, clipped at PATTERN_MAX
        function int run_span();
            if (run_len == 0)
                return 1;
            if (int'(run_len) > PATTERN_MAX)
                return PATTERN_MAX;
            return int'(run_len);
        endfunction

        function pixel_t pattern_color(int pos);
            case (pos)
                0:       return pixel_t'(colors_a[23:0]);
                1:       return pixel_t'(colors_a[47:24]);
                2:       return pixel_t'(colors_b[23:0]);
                3:       return pixel_t'(colors_b[47:24]);
                default: return pixel_t'(color_c);
            endcase
        endfunction

        function bit chan_near(logic [7:0] a, logic [7:0] b);
            int d;
            d = int'(a) - int'(b);
            if (d < 0)
                d = -d;
            return d <= int'(tol);
        endfunction

        function bit pixel_near(pixel_t p, pixel_t c);
            return chan_near(p.red, c.red) && chan_near(p.green, c.green)
                && chan_near(p.blue, c.blue);
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            if (errors <= SHOWN_MAX)
                $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
        endfunction

        // Accepted pixel transaction: advance the model and queue any match it completes
        function void note_pixel(pixel_t p, logic fs);
            int         len;
            int         col;
            bit         hit;
            match_rec_t m;
            if (fs) begin
                col_cnt   = '0;
                row_cnt   = '0;
                match_cnt = '0;
            end
            len = run_span();
            col = int'(col_cnt);
            if (col + 1 >= len && col + 1 < int'(line_w) && row_cnt < row_lim) begin
                hit = pixel_near(p, pattern_color(len - 1));
                for (int i = 0; i + 1 < len; i++)
                    hit = hit && pixel_near(window[len - 2 - i], pattern_color(i));
                if (hit) begin
                    m.x   = COORD_W'(col + 1 - len);
                    m.y   = row_cnt;
                    m.ord = match_cnt;
                    expected_matches.push_back(m);
                    if (match_cnt != ORD_TOP)
                        match_cnt++;
                end
            end
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = p;
            if (col + 1 >= int'(line_w)) begin
                col_cnt = '0;
                if (row_cnt != ROW_TOP)
                    row_cnt++;
            end
            else
                col_cnt = COORD_W'(col + 1);
        endfunction

        // Accepted match transaction: compare with the oldest prediction
        function void check_match(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [ORD_W-1:0] ord);
            match_rec_t e;
            if (expected_matches.size() == 0) begin
                report("match with none pending {x,y,ord}", '0, {16'h0, x, y, ord});
                return;
            end
            e = expected_matches.pop_front();
            if (x !== e.x)
                report("match_x", 64'(e.x), 64'(x));
            if (y !== e.y)
                report("match_y", 64'(e.y), 64'(y));
            if (ord !== e.ord)
                report("match_ordinal", 64'(e.ord), 64'(ord));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  pix_valid     = 1'b0;
    logic                  pix_stall;
    logic [CHAN_W-1:0]     red           = '0;
    logic [CHAN_W-1:0]     green         = '0;
    logic [CHAN_W-1:0]     blue          = '0;
    logic                  frame_start   = 1'b0;
    logic                  match_valid;
    logic                  match_stall   = 1'b0;
    logic [COORD_W-1:0]    match_x;
    logic [COORD_W-1:0]    match_y;
    logic [ORD_W-1:0]      match_ordinal;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    match_tracker tracker;
    bit           calm = 1'b0;
    int           stall_left = 0;
    int           cycles = 0;

    // Opening pixels at the reset settings; bit 24 is frame_start
    logic [24:0] opening [22] = '{
        25'h1_000000, 25'h0_030303, 25'h0_000000, 25'h0_040000, 25'h0_000400,
        25'h0_000004, 25'h0_000000, 25'h0_000000, 25'h0_000000, 25'h0_030003,
        25'h0_000300, 25'h0_FFFFFF, 25'h0_FF0000, 25'h0_00FF00, 25'h0_0000FF,
        25'h1_020102, 25'h0_010203, 25'h0_000000, 25'h0_FEFDFC, 25'h0_7F80FF,
        25'h0_000000, 25'h0_000000
    };

    rgb_run_pattern_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .frame_start   (frame_start),
        .match_valid   (match_valid),
        .match_stall   (match_stall),
        .match_x       (match_x),
        .match_y       (match_y),
        .match_ordinal (match_ordinal),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_stall <= 1'b0;
            stall_left  <= 0;
        end
        else if (calm) begin
            match_stall <= 1'b0;
            stall_left  <= 0;
        end
        else if (stall_left > 0) begin
            match_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end
        else if (!match_stall && $urandom_range(0, 5) == 0) begin
            match_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end
        else
            match_stall <= 1'b0;
    end

    // Monitor: sampled mid-cycle, so both handshakes are settled
    always @(negedge clk)
    begin
        if (rst_n && tracker != null) begin
            if (pix_valid && !pix_stall)
                tracker.note_pixel(pixel_t'({red, green, blue}), frame_start);
            if (match_valid && !match_stall)
                tracker.check_match(match_x, match_y, match_ordinal);
        end
    end

    // One pixel transaction, with an occasional sender gap ahead of it
    task automatic send_pixel(input pixel_t p, input logic fs);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid   <= 1'b1;
        red         <= p.red;
        green       <= p.green;
        blue        <= p.blue;
        frame_start <= fs;
        do @(negedge clk); while (pix_stall);
        @(posedge clk);
    endtask

    // Stop sending and let every predicted match come out
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_reg(input cfg_reg_t r, output logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        v = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_regs();
        logic [63:0] got;
        for (int r = 0; r < NUM_REGS; r++) begin
            read_reg(cfg_reg_t'(r), got);
            if (got !== tracker.reg_value(cfg_reg_t'(r)))
                tracker.report("register readback", tracker.reg_value(cfg_reg_t'(r)), got);
        end
    endtask

    // Write every register while idle, mirror it in the predictor, read it back
    task automatic configure(input logic [47:0] ca, input logic [47:0] cb,
                             input logic [23:0] cc, input logic [2:0] len,
                             input logic [7:0] tl, input logic [11:0] lw,
                             input logic [11:0] rlim);
        logic [63:0] vals [NUM_REGS];
        vals[REG_COLORS_A] = 64'(ca);
        vals[REG_COLORS_B] = 64'(cb);
        vals[REG_COLOR_C]  = 64'(cc);
        vals[REG_RUN_LEN]  = 64'(len);
        vals[REG_TOL]      = 64'(tl);
        vals[REG_LINE_W]   = 64'(lw);
        vals[REG_ROW_LIM]  = 64'(rlim);
        wait_drained();
        for (int r = 0; r < NUM_REGS; r++) begin
            write_reg(cfg_reg_t'(r), vals[r]);
            tracker.set_reg(cfg_reg_t'(r), vals[r]);
        end
        verify_regs();
    endtask

    // Pixel close to a pattern color; when spoiled, one channel is pushed out of tolerance if it fits in 0..255
    function automatic pixel_t near_color(input pixel_t c, input int tl, input bit spoil);
        logic [7:0] base [3];
        logic [7:0] res [3];
        int         d;
        int         v;
        int         pick;
        base = '{c.red, c.green, c.blue};
        for (int i = 0; i < 3; i++) begin
            d = ($urandom_range(0, 3) == 0) ? tl : int'($urandom_range(0, tl));
            v = $urandom_range(0, 1) ? int'(base[i]) + d : int'(base[i]) - d;
            if (v > 255)
                v = 255;
            if (v < 0)
                v = 0;
            res[i] = 8'(v);
        end
        if (spoil) begin
            pick = $urandom_range(0, 2);
            d    = tl + 1 + (($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 20)));
            if ($urandom_range(0, 1) && int'(base[pick]) + d <= 255)
                res[pick] = 8'(int'(base[pick]) + d);
            else if (int'(base[pick]) - d >= 0)
                res[pick] = 8'(int'(base[pick]) - d);
            else if (int'(base[pick]) + d <= 255)
                res[pick] = 8'(int'(base[pick]) + d);
        end
        return pixel_t'({res[0], res[1], res[2]});
    endfunction

    // Mostly the pattern in order with jitter, some spoiled pixels and some noise
    task automatic run_random(input int n, input bit fs_first, input bit quiet,
                              input int pause_at, input int fs_odds);
        int     slot;
        int     roll;
        logic   fs;
        pixel_t p;
        calm = quiet;
        slot = 0;
        for (int k = 0; k < n; k++) begin
            if (k == pause_at)
                wait_drained();
            if (k == 0)
                fs = fs_first;
            else
                fs = (fs_odds > 0) && ($urandom_range(1, fs_odds) == 1);
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                p    = near_color(tracker.pattern_color(slot % tracker.run_span()),
                                  int'(tracker.tol), 1'b0);
                slot = slot + 1;
            end
            else if (roll < 85) begin
                p    = near_color(tracker.pattern_color(slot % tracker.run_span()),
                                  int'(tracker.tol), 1'b1);
                slot = slot + 1;
            end
            else begin
                p    = pixel_t'(24'($urandom));
                slot = 0;
            end
            send_pixel(p, fs);
        end
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, then the opening pixels under them
        verify_regs();
        foreach (opening[i])
            send_pixel(pixel_t'(opening[i][23:0]), opening[i][24]);

        // Longest run, exact match, one pause until drained
        configure(rand48(), rand48(), 24'($urandom), 3'd5, 8'd0, 12'd12, 12'd4095);
        run_random(110, 1'b1, 1'b0, 55, 40);

        // Single pixel run, widest tolerance, narrowest line, few rows
        configure(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 3'd1, 8'd255,
                  12'd2, 12'd3);
        run_random(40, 1'b1, 1'b0, -1, 15);

        // Zero run length counts as one; no idling here
        configure('0, '0, '0, 3'd0, 8'd10, 12'd7, 12'd5);
        run_random(70, 1'b1, 1'b1, -1, 30);

        // Run length above PATTERN_MAX is clipped
        configure(rand48(), rand48(), 24'($urandom), 3'd7, 8'd20, 12'd9, 12'd4095);
        run_random(90, 1'b1, 1'b0, -1, 40);

        // Row limit zero: nothing may match anywhere
        configure(rand48(), rand48(), 24'($urandom), 3'd6, 8'd5, 12'd4095, 12'd0);
        run_random(30, 1'b1, 1'b0, -1, 0);

        configure(rand48(), rand48(), 24'($urandom), 3'd4, 8'd1, 12'd6, 12'd2);
        run_random(100, 1'b1, 1'b0, -1, 25);

        // Closing stretch without idling on either side
        configure(rand48(), rand48(), 24'($urandom), 3'd2, 8'd8, 12'd5, 12'd4095);
        run_random(180, 1'b1, 1'b1, -1, 40);

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
